// File: src/qpr_pkg.sv
package qpr_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  localparam logic [DATA_WIDTH-1:0] DMAX_V = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] DMIN_V = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // The real part 1.0 used when rotating; it clips when the format cannot hold it.
  localparam logic ONE_SAT = (FRAC_BITS >= DATA_WIDTH - 1);
  localparam logic [DATA_WIDTH-1:0] ONE_V =
    ONE_SAT ? DMAX_V : DATA_WIDTH'(64'd1 << FRAC_BITS);

  localparam logic CMD_MUL = 1'b0;
  localparam logic CMD_ROT = 1'b1;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] x;
    logic signed [DATA_WIDTH-1:0] y;
    logic signed [DATA_WIDTH-1:0] z;
    logic signed [DATA_WIDTH-1:0] w;
  } quat_t;

  typedef struct packed {
    logic                         command;
    logic signed [DATA_WIDTH-1:0] left_x;
    logic signed [DATA_WIDTH-1:0] left_y;
    logic signed [DATA_WIDTH-1:0] left_z;
    logic signed [DATA_WIDTH-1:0] left_w;
    logic signed [DATA_WIDTH-1:0] right_x;
    logic signed [DATA_WIDTH-1:0] right_y;
    logic signed [DATA_WIDTH-1:0] right_z;
    logic signed [DATA_WIDTH-1:0] right_w;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] out_x;
    logic signed [DATA_WIDTH-1:0] out_y;
    logic signed [DATA_WIDTH-1:0] out_z;
    logic signed [DATA_WIDTH-1:0] out_w;
    logic                         saturated;
  } out_item_t;

  // Data that rides alongside a product through one multiplier pipeline.
  typedef struct packed {
    logic  cmd;
    logic  sat;
    quat_t q;
  } side_t;

  typedef struct packed {
    logic                  sat;
    logic [DATA_WIDTH-1:0] v;
  } sval_t;

  // Saturating add or subtract of two words.
  function automatic sval_t sat_add(input logic [DATA_WIDTH-1:0] a,
                                    input logic [DATA_WIDTH-1:0] b,
                                    input logic sub);
    logic [DATA_WIDTH:0] s;
    sval_t r;
    if (sub) begin
      s = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
    end else begin
      s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
    end
    if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
      r.sat = 1'b1;
      r.v   = s[DATA_WIDTH] ? DMIN_V : DMAX_V;
    end else begin
      r.sat = 1'b0;
      r.v   = s[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

  // Full product shifted right by FRAC_BITS (floor) and clipped. A negative
  // product whose magnitude reaches the most negative value exactly is flagged.
  function automatic sval_t sat_prod(input logic [2*DATA_WIDTH-1:0] p);
    logic [DATA_WIDTH-FRAC_BITS:0] upper;
    logic [DATA_WIDTH-2:0]         mid;
    logic [FRAC_BITS-1:0]          low;
    sval_t r;
    upper = p[2*DATA_WIDTH-1:DATA_WIDTH-1+FRAC_BITS];
    mid   = p[DATA_WIDTH-2+FRAC_BITS:FRAC_BITS];
    low   = p[FRAC_BITS-1:0];
    r.sat = 1'b0;
    r.v   = p[DATA_WIDTH-1+FRAC_BITS:FRAC_BITS];
    if (!p[2*DATA_WIDTH-1]) begin
      if (upper != '0) begin
        r.sat = 1'b1;
        r.v   = DMAX_V;
      end
    end else begin
      if (upper != '1) begin
        r.sat = 1'b1;
        r.v   = DMIN_V;
      end else if (mid == '0 && low == '0) begin
        r.sat = 1'b1;
        r.v   = DMIN_V;
      end
    end
    return r;
  endfunction

endpackage

// File: src/qpr_qmul.sv
module qpr_qmul (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  qpr_pkg::quat_t   in_a,
  input  qpr_pkg::quat_t   in_b,
  input  qpr_pkg::side_t   in_side,
  output logic             out_valid,
  input  logic             out_stall,
  output qpr_pkg::quat_t   out_prod,
  output logic             out_sat,
  output qpr_pkg::side_t   out_side
);
  import qpr_pkg::*;

  // Component order is x, y, z, w. Term k of component c multiplies
  // a[A_SEL[c][k]] by b[B_SEL[k]]; SUB_T marks terms that are subtracted.
  localparam logic [1:0] A_SEL [4][4] = '{'{2'd0, 2'd3, 2'd2, 2'd1},
                                          '{2'd1, 2'd2, 2'd3, 2'd0},
                                          '{2'd2, 2'd1, 2'd0, 2'd3},
                                          '{2'd3, 2'd0, 2'd1, 2'd2}};
  localparam logic [1:0] B_SEL [4] = '{2'd3, 2'd0, 2'd1, 2'd2};
  localparam logic [3:0] SUB_T [4] = '{4'b0100, 4'b1000, 4'b0010, 4'b1110};

  logic [4:0] v_r;
  logic [4:0] en;

  logic signed [DATA_WIDTH-1:0]   av [4];
  logic signed [DATA_WIDTH-1:0]   bv [4];
  logic signed [2*DATA_WIDTH-1:0] m_nxt [4][4];
  logic signed [2*DATA_WIDTH-1:0] m_r [4][4];
  sval_t                          c_nxt [4][4];
  logic [DATA_WIDTH-1:0]          c_r [4][4];
  logic [15:0]                    cflag;
  sval_t                          s1_nxt [4];
  logic [DATA_WIDTH-1:0]          s1_r [4];
  logic [DATA_WIDTH-1:0]          t2_r [4];
  logic [DATA_WIDTH-1:0]          t3_r [4];
  sval_t                          s2_nxt [4];
  logic [DATA_WIDTH-1:0]          s2_r [4];
  logic [DATA_WIDTH-1:0]          u3_r [4];
  sval_t                          q_nxt [4];
  logic [DATA_WIDTH-1:0]          q_r [4];
  logic [3:0]                     f3, f4, f5;

  logic  sat2_r, sat3_r, sat4_r, sat5_r;
  side_t side1_r, side2_r, side3_r, side4_r, side5_r;

  // A stage takes new data when it is empty or when the stage after it moves.
  always_comb begin
    en[4] = !v_r[4] || !out_stall;
    en[3] = !v_r[3] || en[4];
    en[2] = !v_r[2] || en[3];
    en[1] = !v_r[1] || en[2];
    en[0] = !v_r[0] || en[1];
  end

  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
      if (en[3]) v_r[3] <= v_r[2];
      if (en[4]) v_r[4] <= v_r[3];
    end
  end

  assign av[0] = in_a.x;
  assign av[1] = in_a.y;
  assign av[2] = in_a.z;
  assign av[3] = in_a.w;
  assign bv[0] = in_b.x;
  assign bv[1] = in_b.y;
  assign bv[2] = in_b.z;
  assign bv[3] = in_b.w;

  for (genvar c = 0; c < 4; c++) begin : g_comp
    for (genvar k = 0; k < 4; k++) begin : g_term
      assign m_nxt[c][k]     = (2*DATA_WIDTH)'(av[A_SEL[c][k]]) *
                               (2*DATA_WIDTH)'(bv[B_SEL[k]]);
      assign c_nxt[c][k]     = sat_prod(m_r[c][k]);
      assign cflag[4*c + k]  = c_nxt[c][k].sat;

      always_ff @(posedge clk) begin
        if (en[0]) m_r[c][k] <= m_nxt[c][k];
        if (en[1]) c_r[c][k] <= c_nxt[c][k].v;
      end
    end

    assign s1_nxt[c] = sat_add(c_r[c][0], c_r[c][1], SUB_T[c][1]);
    assign s2_nxt[c] = sat_add(s1_r[c], t2_r[c], SUB_T[c][2]);
    assign q_nxt[c]  = sat_add(s2_r[c], u3_r[c], SUB_T[c][3]);
    assign f3[c]     = s1_nxt[c].sat;
    assign f4[c]     = s2_nxt[c].sat;
    assign f5[c]     = q_nxt[c].sat;

    always_ff @(posedge clk) begin
      if (en[2]) begin
        s1_r[c] <= s1_nxt[c].v;
        t2_r[c] <= c_r[c][2];
        t3_r[c] <= c_r[c][3];
      end
      if (en[3]) begin
        s2_r[c] <= s2_nxt[c].v;
        u3_r[c] <= t3_r[c];
      end
      if (en[4]) begin
        q_r[c] <= q_nxt[c].v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) side1_r <= in_side;
    if (en[1]) begin
      side2_r <= side1_r;
      sat2_r  <= |cflag;
    end
    if (en[2]) begin
      side3_r <= side2_r;
      sat3_r  <= sat2_r | (|f3);
    end
    if (en[3]) begin
      side4_r <= side3_r;
      sat4_r  <= sat3_r | (|f4);
    end
    if (en[4]) begin
      side5_r <= side4_r;
      sat5_r  <= sat4_r | (|f5);
    end
  end

  assign out_valid  = v_r[4];
  assign out_prod.x = q_r[0];
  assign out_prod.y = q_r[1];
  assign out_prod.z = q_r[2];
  assign out_prod.w = q_r[3];
  assign out_sat    = sat5_r;
  assign out_side   = side5_r;

endmodule

// File: src/quaternion_product_and_rotation_unit.sv
// Quaternion product and vector rotation, signed fixed point (Q16.16).
// Input channel: in_valid / in_stall with one in_data item per handshake.
// Command 0 returns left * right. Command 1 rotates (right_x, right_y, right_z)
// by left, computing left * (v, 1.0) * conj(left); out_w carries the real part.
// Every component product and every sum saturates; saturated reports any clip.
// Output channel: out_valid / out_stall with one out_data item per input item,
// in the order the items came in.
// From acceptance to out_valid an item passes one input register, two
// five-stage multiplier pipelines (multiply, shift and clip, three sums) and
// the output register. One item per cycle is accepted while out_stall is low.
// While out_stall is high the output holds its item and the pipelines keep
// moving until they fill, after which in_stall rises; nothing is dropped.
// Synchronous reset empties every stage; the first item may follow at once.
module quaternion_product_and_rotation_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  qpr_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output qpr_pkg::out_item_t   out_data
);
  import qpr_pkg::*;

  logic  s0_v_r;
  quat_t s0_a_r, s0_b_r;
  side_t s0_side_r;
  logic  en0;

  quat_t b_nxt;
  side_t side_nxt;
  sval_t nx, ny, nz;

  logic  a_stall, a_valid, a_sat;
  quat_t a_prod;
  side_t a_side, b_in_side;

  logic  b_stall, b_valid, b_sat;
  quat_t b_prod;
  side_t b_side;

  logic      en_o;
  logic      out_valid_r;
  out_item_t out_nxt, out_data_r;

  assign en0      = !s0_v_r || !a_stall;
  assign in_stall = !en0;

  // Conjugate of the left quaternion, needed by the second product when rotating.
  always_comb begin
    nx = sat_add('0, in_data.left_x, 1'b1);
    ny = sat_add('0, in_data.left_y, 1'b1);
    nz = sat_add('0, in_data.left_z, 1'b1);

    b_nxt.x = in_data.right_x;
    b_nxt.y = in_data.right_y;
    b_nxt.z = in_data.right_z;
    b_nxt.w = (in_data.command == CMD_ROT) ? ONE_V : in_data.right_w;

    side_nxt.cmd = in_data.command;
    side_nxt.q.x = nx.v;
    side_nxt.q.y = ny.v;
    side_nxt.q.z = nz.v;
    side_nxt.q.w = in_data.left_w;
    side_nxt.sat = (in_data.command == CMD_ROT) && (ONE_SAT || nx.sat || ny.sat || nz.sat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en0) begin
      s0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      s0_a_r.x  <= in_data.left_x;
      s0_a_r.y  <= in_data.left_y;
      s0_a_r.z  <= in_data.left_z;
      s0_a_r.w  <= in_data.left_w;
      s0_b_r    <= b_nxt;
      s0_side_r <= side_nxt;
    end
  end

  qpr_qmul u_mul_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s0_v_r),
    .in_stall  (a_stall),
    .in_a      (s0_a_r),
    .in_b      (s0_b_r),
    .in_side   (s0_side_r),
    .out_valid (a_valid),
    .out_stall (b_stall),
    .out_prod  (a_prod),
    .out_sat   (a_sat),
    .out_side  (a_side)
  );

  // The second product multiplies by the conjugate; the first product rides
  // along so that a plain multiply can leave with it.
  always_comb begin
    b_in_side.cmd = a_side.cmd;
    b_in_side.sat = a_side.sat | a_sat;
    b_in_side.q   = a_prod;
  end

  qpr_qmul u_mul_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (a_valid),
    .in_stall  (b_stall),
    .in_a      (a_prod),
    .in_b      (a_side.q),
    .in_side   (b_in_side),
    .out_valid (b_valid),
    .out_stall (!en_o),
    .out_prod  (b_prod),
    .out_sat   (b_sat),
    .out_side  (b_side)
  );

  assign en_o = !out_valid_r || !out_stall;

  always_comb begin
    if (b_side.cmd == CMD_ROT) begin
      out_nxt.out_x     = b_prod.x;
      out_nxt.out_y     = b_prod.y;
      out_nxt.out_z     = b_prod.z;
      out_nxt.out_w     = b_prod.w;
      out_nxt.saturated = b_side.sat | b_sat;
    end else begin
      out_nxt.out_x     = b_side.q.x;
      out_nxt.out_y     = b_side.q.y;
      out_nxt.out_z     = b_side.q.z;
      out_nxt.out_w     = b_side.q.w;
      out_nxt.saturated = b_side.sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_o) begin
      out_valid_r <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: src/qpr_check.sv
module qpr_check (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input qpr_pkg::in_item_t   in_data,
  input logic                out_valid,
  input logic                out_stall,
  input qpr_pkg::out_item_t  out_data
);
  import qpr_pkg::*;

  localparam int LAT = 12;

  // Number of consecutive edges, up to the latency, at which out_stall was low.
  logic [3:0] run_r;
  logic       run_full;
  logic       ident_mul;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
    end else if (out_stall) begin
      run_r <= '0;
    end else if (run_r != 4'(LAT)) begin
      run_r <= run_r + 4'd1;
    end
  end

  assign run_full  = (run_r == 4'(LAT));
  assign ident_mul = (in_data.command == CMD_MUL) && (in_data.left_x == '0) &&
                     (in_data.left_y == '0) && (in_data.left_z == '0) &&
                     (in_data.left_w == ONE_V);

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output item changed or vanished");

  a_no_false_stall: assert property (@(posedge clk)
    !out_stall |-> !in_stall)
    else $error("input stalled while the output was moving");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_valid && !in_stall, LAT) && run_full |-> out_valid)
    else $error("item did not arrive after the pipeline latency");

  a_identity: assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_valid && !in_stall && ident_mul, LAT) && run_full |->
      out_data.out_x == $past(in_data.right_x, LAT) &&
      out_data.out_y == $past(in_data.right_y, LAT) &&
      out_data.out_z == $past(in_data.right_z, LAT) &&
      out_data.out_w == $past(in_data.right_w, LAT) && !out_data.saturated)
    else $error("product with the unit quaternion changed the operand");

endmodule

bind quaternion_product_and_rotation_unit qpr_check u_qpr_check (.*);
